// ===== sv/ckt_pkg.sv =====
// ----------------------------------------------------------------------------
// ckt_pkg
// shared types and constants for the chord to key event typer
// ----------------------------------------------------------------------------
package ckt_pkg;

    localparam int MAX_MODS    = 4;
    localparam int CHORD_SLOTS = 4;
    localparam int MOD_LIMIT   = (MAX_MODS < CHORD_SLOTS) ? MAX_MODS : CHORD_SLOTS;
    localparam int CNT_W       = $clog2(MAX_MODS + 1);
    localparam int IDX_W       = (MAX_MODS > 1) ? $clog2(MAX_MODS) : 1;
    localparam int SLOT_W      = $clog2(CHORD_SLOTS);
    localparam int WANT_W      = 3;

    localparam logic [1:0] MODE_CHORD = 2'd0;
    localparam logic [1:0] MODE_END   = 2'd1;
    localparam logic [1:0] MODE_ABORT = 2'd2;

    localparam logic [1:0] STAT_RUN    = 2'd0;
    localparam logic [1:0] STAT_DONE   = 2'd1;
    localparam logic [1:0] STAT_CANCEL = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [7:0]        key_code;
        logic [WANT_W-1:0] mod_count;
        logic [7:0]        mod_a;
        logic [7:0]        mod_b;
        logic [7:0]        mod_c;
        logic [7:0]        mod_d;
    } req_t;

    typedef struct packed {
        logic [7:0] scancode;
        logic       key_down;
        logic       event_valid;
        logic [1:0] finish_status;
        logic       last;
    } evt_t;

    typedef struct packed {
        logic             clear;
        logic             remove;
        logic [IDX_W-1:0] rm_idx;
        logic             append;
        logic [7:0]       app_val;
        logic [IDX_W-1:0] rd_idx;
        logic [7:0]       probe;
    } held_ctl_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [7:0]       rd_data;
        logic             probe_hit;
    } held_sts_t;

endpackage

// ===== sv/ckt_held_list.sv =====
// ----------------------------------------------------------------------------
// ckt_held_list
// ordered list of held modifiers, oldest first, with clear, remove and append
// ----------------------------------------------------------------------------
module ckt_held_list
    import ckt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  held_ctl_t ctl,
    output held_sts_t sts
);

    logic [7:0]       mods_reg [MAX_MODS];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] app_idx;
    logic [MAX_MODS-1:0] hit_vec;

    assign app_idx = count_reg[IDX_W-1:0];

    genvar j;
    generate
        for (j = 0; j < MAX_MODS; j++)
        begin : g_entry
            if (j < MAX_MODS - 1)
            begin : g_shift
                always_ff @(posedge clk)
                begin
                    if (ctl.remove && (IDX_W'(j) >= ctl.rm_idx))
                    begin
                        mods_reg[j] <= mods_reg[j + 1];
                    end
                    else if (ctl.append && (app_idx == IDX_W'(j)))
                    begin
                        mods_reg[j] <= ctl.app_val;
                    end
                end
            end
            else
            begin : g_tail
                always_ff @(posedge clk)
                begin
                    if (ctl.append && (app_idx == IDX_W'(j)))
                    begin
                        mods_reg[j] <= ctl.app_val;
                    end
                end
            end

            assign hit_vec[j] = (CNT_W'(j) < count_reg) && (mods_reg[j] == ctl.probe);
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.remove)
        begin
            count_next = count_reg - 1'b1;
        end
        else if (ctl.append)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign sts.count     = count_reg;
    assign sts.rd_data   = mods_reg[ctl.rd_idx];
    assign sts.probe_hit = |hit_vec;

endmodule

// ===== sv/chord_to_key_event_typer_top.sv =====
// ----------------------------------------------------------------------------
// chord_to_key_event_typer_top
// turns chord, end and abort beats into key press and release events
// ----------------------------------------------------------------------------
// the req channel takes one beat at a time: a chord, an end of text or an
// abort. req_ready is high only while the sequencer is idle. each beat walks
// the held modifier list newest first (one entry per cycle while the output
// is not stalled) to release what is not wanted, then walks the chord slots
// in order (one per cycle while not stalled) to press what is missing, then
// emits key down and key up. end and abort release all held modifiers and
// emit one status beat. each beat returns to the idle state, with req_ready
// high, before the next beat is taken. the last result of each beat carries
// last. a mode of 3 is taken while idle with no result.
// results leave through one output register on the evt channel; a stalled
// receiver holds that register and the sequencer waits with it, so nothing
// is lost. a step that emits a result registers it in that output register;
// the idle state that takes the req beat emits no result itself.
// reset clears the held count and the sequencer; the held scancodes are
// not cleared and are only read below the held count.
// ----------------------------------------------------------------------------
module chord_to_key_event_typer_top
    import ckt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic evt_valid,
    input  logic evt_ready,
    output evt_t evt
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REL,
        S_PRESS,
        S_KDN,
        S_KUP,
        S_STAT
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WANT_W-1:0] pidx_reg, pidx_next;
    logic [WANT_W-1:0] want_n_reg, want_n_next;
    logic [7:0]        want_reg [CHORD_SLOTS];
    logic [7:0]        key_reg;
    logic              end_reg, end_next;
    logic [1:0]        stat_reg, stat_next;
    logic              evt_valid_reg, evt_valid_next;
    evt_t              evt_reg, evt_next;

    held_ctl_t         ctl;
    held_sts_t         sts;

    logic              accept;
    logic              adv;
    logic [WANT_W-1:0] req_want_n;
    logic [CNT_W-1:0]  cnt_dec;
    logic [WANT_W-1:0] pidx_inc;
    logic [CHORD_SLOTS-1:0] want_hit_vec;
    logic              want_hit;
    logic [7:0]        press_val;

    ckt_held_list u_held (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .sts   (sts)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign adv       = !evt_valid_reg || evt_ready;
    assign cnt_dec   = cnt_reg - 1'b1;
    assign pidx_inc  = pidx_reg + 1'b1;
    assign press_val = want_reg[pidx_reg[SLOT_W-1:0]];

    assign req_want_n = (req.mod_count > WANT_W'(MOD_LIMIT)) ? WANT_W'(MOD_LIMIT)
                                                              : req.mod_count;

    genvar k;
    generate
        for (k = 0; k < CHORD_SLOTS; k++)
        begin : g_want
            assign want_hit_vec[k] = (WANT_W'(k) < want_n_reg) &&
                                     (want_reg[k] == sts.rd_data);
        end
    endgenerate

    assign want_hit = |want_hit_vec;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pidx_next      = pidx_reg;
        want_n_next    = want_n_reg;
        end_next       = end_reg;
        stat_next      = stat_reg;
        evt_valid_next = evt_valid_reg;
        evt_next       = evt_reg;

        ctl         = '0;
        ctl.rd_idx  = cnt_dec[IDX_W-1:0];
        ctl.rm_idx  = cnt_dec[IDX_W-1:0];
        ctl.probe   = press_val;
        ctl.app_val = press_val;

        if (evt_valid_reg && evt_ready)
        begin
            evt_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && ((req.mode == MODE_CHORD) || (req.mode == MODE_END) ||
                               (req.mode == MODE_ABORT)))
                begin
                    want_n_next = req_want_n;
                    end_next    = (req.mode != MODE_CHORD);
                    stat_next   = (req.mode == MODE_END) ? STAT_DONE : STAT_CANCEL;
                    cnt_next    = sts.count;
                    pidx_next   = '0;
                    if (sts.count != '0)
                    begin
                        state_next = S_REL;
                    end
                    else if (req.mode != MODE_CHORD)
                    begin
                        state_next = S_STAT;
                    end
                    else if (req_want_n != '0)
                    begin
                        state_next = S_PRESS;
                    end
                    else
                    begin
                        state_next = S_KDN;
                    end
                end
            end

            S_REL:
            begin
                if (adv)
                begin
                    if (end_reg || !want_hit)
                    begin
                        ctl.remove               = 1'b1;
                        evt_valid_next           = 1'b1;
                        evt_next.scancode        = sts.rd_data;
                        evt_next.key_down        = 1'b0;
                        evt_next.event_valid     = 1'b1;
                        evt_next.finish_status   = STAT_RUN;
                        evt_next.last            = 1'b0;
                    end
                    cnt_next = cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        if (end_reg)
                        begin
                            state_next = S_STAT;
                        end
                        else if (want_n_reg != '0)
                        begin
                            state_next = S_PRESS;
                        end
                        else
                        begin
                            state_next = S_KDN;
                        end
                    end
                end
            end

            S_PRESS:
            begin
                if (adv)
                begin
                    if (!sts.probe_hit && (sts.count < CNT_W'(MOD_LIMIT)))
                    begin
                        ctl.append               = 1'b1;
                        evt_valid_next           = 1'b1;
                        evt_next.scancode        = press_val;
                        evt_next.key_down        = 1'b1;
                        evt_next.event_valid     = 1'b1;
                        evt_next.finish_status   = STAT_RUN;
                        evt_next.last            = 1'b0;
                    end
                    pidx_next = pidx_inc;
                    if (pidx_inc == want_n_reg)
                    begin
                        state_next = S_KDN;
                    end
                end
            end

            S_KDN:
            begin
                if (adv)
                begin
                    evt_valid_next         = 1'b1;
                    evt_next.scancode      = key_reg;
                    evt_next.key_down      = 1'b1;
                    evt_next.event_valid   = 1'b1;
                    evt_next.finish_status = STAT_RUN;
                    evt_next.last          = 1'b0;
                    state_next             = S_KUP;
                end
            end

            S_KUP:
            begin
                if (adv)
                begin
                    evt_valid_next         = 1'b1;
                    evt_next.scancode      = key_reg;
                    evt_next.key_down      = 1'b0;
                    evt_next.event_valid   = 1'b1;
                    evt_next.finish_status = STAT_RUN;
                    evt_next.last          = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            S_STAT:
            begin
                if (adv)
                begin
                    ctl.clear              = 1'b1;
                    evt_valid_next         = 1'b1;
                    evt_next.scancode      = '0;
                    evt_next.key_down      = 1'b0;
                    evt_next.event_valid   = 1'b0;
                    evt_next.finish_status = stat_reg;
                    evt_next.last          = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pidx_reg      <= '0;
            want_n_reg    <= '0;
            end_reg       <= 1'b0;
            stat_reg      <= STAT_RUN;
            evt_valid_reg <= 1'b0;
            evt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pidx_reg      <= pidx_next;
            want_n_reg    <= want_n_next;
            end_reg       <= end_next;
            stat_reg      <= stat_next;
            evt_valid_reg <= evt_valid_next;
            evt_reg       <= evt_next;
        end
    end

    // chord payload latch
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg     <= req.key_code;
            want_reg[0] <= req.mod_a;
            want_reg[1] <= req.mod_b;
            want_reg[2] <= req.mod_c;
            want_reg[3] <= req.mod_d;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

endmodule
